### hw/rtl/hlsrgb_pkg.sv
// hlsrgb_pkg: shared constants, types and helpers for the hls to rgb converter
// no dependencies; used by every module of the block
`default_nettype none

package hlsrgb_pkg;

  // level format, unsigned q1.frac
  localparam int FRAC_BITS     = 16;
  localparam int HUE_FRAC_BITS = 6;
  localparam int IN_W          = 17;
  localparam int LVL_W         = FRAC_BITS + 1;
  localparam int BYTE_W        = 8;

  localparam logic [LVL_W-1:0] LVL_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] LVL_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  // hue in fractions of a degree
  localparam int DEG60  = 60 * (2 ** HUE_FRAC_BITS);
  localparam int DEG360 = 6 * DEG60;
  localparam int HUE_W  = $clog2(DEG360);
  localparam int ABS_W  = $clog2(DEG60 + 1);

  // hue wrap: add whole turns so every input is positive, then take turns off
  localparam int HUE_SPAN   = 2 ** (IN_W - 1);
  localparam int WRAP_TURNS = (HUE_SPAN + DEG360 - 1) / DEG360;
  localparam int HUE_OFS    = WRAP_TURNS * DEG360;
  localparam int WRAP_MAX   = HUE_SPAN - 1 + HUE_OFS;
  localparam int WRAP_W     = $clog2(WRAP_MAX + 1);
  localparam int WRAP_N     = WRAP_MAX / DEG360;

  // ratio |f| * 2^frac / 60 deg: 60 deg is an odd divisor shifted left
  localparam int RATIO_PRE = FRAC_BITS - 2 - HUE_FRAC_BITS;
  localparam int RATIO_DIV = DEG60 / (2 ** (2 + HUE_FRAC_BITS));
  localparam int NUM_W     = ABS_W + RATIO_PRE;
  localparam int RECIP_SH  = 24;
  localparam int RECIP     = (2 ** RECIP_SH + RATIO_DIV - 1) / RATIO_DIV;
  localparam int RECIP_W   = $clog2(RECIP + 1);

  // square root pipeline
  localparam int SQ_STEPS     = LVL_W;
  localparam int RAD_W        = 2 * SQ_STEPS;
  localparam int REM_W        = SQ_STEPS + 4;
  localparam int SQ_PER_STAGE = 3;
  localparam int SQ_STAGES    = (SQ_STEPS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

  // 60 degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // side data that travels with a colour through the root pipeline
  typedef struct packed {
    logic              special;
    logic [BYTE_W-1:0] grey;
    logic [LVL_W-1:0]  lo;
    logic [LVL_W-1:0]  span;
    sector_t           sector;
  } mix_t;

  // floor(level * 255 / one)
  function automatic logic [BYTE_W-1:0] to_byte(input logic [LVL_W-1:0] lvl);
    logic [LVL_W+BYTE_W-1:0] scaled;
    scaled = {lvl, {BYTE_W{1'b0}}} - (LVL_W + BYTE_W)'(lvl);
    return scaled[FRAC_BITS +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/hlsrgb_front.sv
// hlsrgb_front: clamp, spread, hue wrap, sector and hue ratio in four stages
// depends on hlsrgb_pkg
`default_nettype none

module hlsrgb_front
  import hlsrgb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [IN_W-1:0]  hue_deg,
  input  wire logic [IN_W-1:0]         lightness,
  input  wire logic [IN_W-1:0]         saturation,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [LVL_W-1:0]             ratio,
  output mix_t                         info
);

  // stage registers
  logic                 v1, v2, v3, v4;
  logic                 rdy1, rdy2, rdy3, rdy4;
  logic [LVL_W-1:0]     l1, s1, l2;
  logic [FRAC_BITS-1:0] x1, d2;
  logic [WRAP_W-1:0]    hw1;
  logic [HUE_W-1:0]     h2;
  mix_t                 info3, info4;
  logic [ABS_W-1:0]     abs3;
  logic [LVL_W-1:0]     ratio4;

  // combinational values between stages
  logic [LVL_W-1:0]           l_clamp, s_clamp, lx;
  logic [FRAC_BITS-1:0]       x_next;
  logic [WRAP_W:0]            hue_sum;
  logic [LVL_W+FRAC_BITS-1:0] sx_prod;
  logic [FRAC_BITS-1:0]       d_next;
  logic [WRAP_W-1:0]          wrap_sub, h_diff;
  logic [HUE_W-1:0]           h_next;
  sector_t                    sec_next;
  logic [HUE_W-1:0]           af_wide;
  mix_t                       info_next;
  logic [NUM_W-1:0]           num;
  logic [NUM_W+RECIP_W-1:0]   rprod;
  logic [LVL_W-1:0]           ratio_next;

  // ready chain, a stage moves when empty or when the next one moves
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: clamp, pick the spread factor, lift hue into positive range
  assign l_clamp = (lightness > LVL_ONE) ? LVL_ONE : lightness;
  assign s_clamp = (saturation > LVL_ONE) ? LVL_ONE : saturation;
  assign lx      = (l_clamp <= LVL_HALF) ? l_clamp : LVL_ONE - l_clamp;
  assign x_next  = lx[FRAC_BITS-1:0];
  assign hue_sum = {{(WRAP_W + 1 - IN_W){hue_deg[IN_W-1]}}, hue_deg}
                 + (WRAP_W + 1)'(HUE_OFS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      l1  <= l_clamp;
      s1  <= s_clamp;
      x1  <= x_next;
      hw1 <= hue_sum[WRAP_W-1:0];
    end
  end

  // stage 2: spread d and hue brought into one turn
  assign sx_prod = s1 * x1;
  assign d_next  = sx_prod[FRAC_BITS +: FRAC_BITS];

  always_comb begin
    wrap_sub = '0;
    for (int k = 1; k <= WRAP_N; k++) begin
      if (hw1 >= WRAP_W'(k * DEG360)) wrap_sub = WRAP_W'(k * DEG360);
    end
    h_diff = hw1 - wrap_sub;
  end
  assign h_next = h_diff[HUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      l2 <= l1;
      d2 <= d_next;
      h2 <= h_next;
    end
  end

  // stage 3: low level, span, sector and distance to the nearest primary
  always_comb begin
    sec_next = SEC_RED_YEL;
    for (int k = 1; k < 6; k++) begin
      if (h2 >= HUE_W'(k * DEG60)) sec_next = sector_t'(3'(k));
    end
  end

  always_comb begin
    unique case (sec_next)
      SEC_RED_YEL: af_wide = h2;
      SEC_YEL_GRN: af_wide = HUE_W'(2 * DEG60) - h2;
      SEC_GRN_CYN: af_wide = h2 - HUE_W'(2 * DEG60);
      SEC_CYN_BLU: af_wide = HUE_W'(4 * DEG60) - h2;
      SEC_BLU_MAG: af_wide = h2 - HUE_W'(4 * DEG60);
      default:     af_wide = HUE_W'(DEG360) - h2;
    endcase
  end

  always_comb begin
    info_next.special = (d2 == '0);
    info_next.grey    = to_byte(l2);
    info_next.lo      = l2 - LVL_W'(d2);
    info_next.span    = {d2, 1'b0};
    info_next.sector  = sec_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      info3 <= info_next;
      abs3  <= af_wide[ABS_W-1:0];
    end
  end

  // stage 4: ratio by reciprocal multiply, exact over the whole abs range
  assign num        = {abs3, {RATIO_PRE{1'b0}}};
  assign rprod      = num * RECIP_W'(RECIP);
  assign ratio_next = rprod[RECIP_SH +: LVL_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      info4  <= info3;
      ratio4 <= ratio_next;
    end
  end

  assign out_valid = v4;
  assign ratio     = ratio4;
  assign info      = info4;

`ifndef SYNTH
  // a beat leaving stage 1 always lands in stage 2
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    (v1 && rdy2) |=> v2)
    else $error("front: beat lost between stage 1 and stage 2");

  // wrapped hue is inside one turn
  a_hue_wrap: assert property (@(posedge clk) disable iff (rst)
    (v1 && rdy2) |=> (h2 < HUE_W'(DEG360)))
    else $error("front: hue not wrapped into one turn");
`endif

endmodule

`default_nettype wire

### hw/rtl/hlsrgb_sqrt.sv
// hlsrgb_sqrt: pipelined digit-by-digit square root of ratio << frac bits
// depends on hlsrgb_pkg; carries the mix side data alongside
`default_nettype none

module hlsrgb_sqrt
  import hlsrgb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [LVL_W-1:0] ratio,
  input  wire mix_t             in_info,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SQ_STEPS-1:0]   root,
  output mix_t                  out_info
);

  // per-stage registers
  logic                v     [SQ_STAGES];
  logic                rdy   [SQ_STAGES+1];
  logic [RAD_W-1:0]    rad_q [SQ_STAGES];
  logic [REM_W-1:0]    rem_q [SQ_STAGES];
  logic [SQ_STEPS-1:0] root_q[SQ_STAGES];
  mix_t                info_q[SQ_STAGES];

  assign rdy[SQ_STAGES] = out_ready;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic                v_in;
    logic [RAD_W-1:0]    rad_in, rad_c;
    logic [REM_W-1:0]    rem_in, rem_c, rem_sh, trial;
    logic [SQ_STEPS-1:0] root_in, root_c;
    mix_t                info_in;

    // stage input: module port for the first stage, previous stage otherwise
    if (g == 0) begin : g_head
      assign v_in    = in_valid;
      assign rad_in  = RAD_W'({ratio, {FRAC_BITS{1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
      assign info_in = in_info;
    end else begin : g_body
      assign v_in    = v[g-1];
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign info_in = info_q[g-1];
    end

    assign rdy[g] = !v[g] || rdy[g+1];

    // a few root bits per stage, two radicand bits each
    always_comb begin
      rad_c  = rad_in;
      rem_c  = rem_in;
      root_c = root_in;
      rem_sh = '0;
      trial  = '0;
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
        if (g * SQ_PER_STAGE + j < SQ_STEPS) begin
          rem_sh = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
          trial  = REM_W'({root_c, 2'b01});
          rad_c  = rad_c << 2;
          if (rem_sh >= trial) begin
            rem_c  = rem_sh - trial;
            root_c = {root_c[SQ_STEPS-2:0], 1'b1};
          end else begin
            rem_c  = rem_sh;
            root_c = {root_c[SQ_STEPS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (rdy[g]) begin
        v[g] <= v_in;
      end
      if (rdy[g] && v_in) begin
        rad_q[g]  <= rad_c;
        rem_q[g]  <= rem_c;
        root_q[g] <= root_c;
        info_q[g] <= info_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[SQ_STAGES-1];
  assign root      = root_q[SQ_STAGES-1];
  assign out_info  = info_q[SQ_STAGES-1];

`ifndef SYNTH
  // a finished root leaves a remainder of at most twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    v[SQ_STAGES-1] |->
      (rem_q[SQ_STAGES-1] <= REM_W'({root_q[SQ_STAGES-1], 1'b0})))
    else $error("sqrt: remainder too large, root not floored");
`endif

endmodule

`default_nettype wire

### hw/rtl/hlsrgb_mix.sv
// hlsrgb_mix: middle level, channel order by sector, byte scaling
// depends on hlsrgb_pkg; last stage is the output register
`default_nettype none

module hlsrgb_mix
  import hlsrgb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SQ_STEPS-1:0] root,
  input  wire mix_t                in_info,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [BYTE_W-1:0]        red,
  output logic [BYTE_W-1:0]        green,
  output logic [BYTE_W-1:0]        blue
);

  logic                         v1, v2, rdy1, rdy2;
  logic [LVL_W+SQ_STEPS-1:0]    prod1, prod_next;
  mix_t                         info1;
  logic [LVL_W-1:0]             mid, hi;
  logic [BYTE_W-1:0]            lo_b, mid_b, hi_b;
  logic [BYTE_W-1:0]            red_next, green_next, blue_next;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage 1: span times root
  assign prod_next = in_info.span * root;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      prod1 <= prod_next;
      info1 <= in_info;
    end
  end

  // stage 2: levels to bytes, ordered by sector
  assign mid   = info1.lo + prod1[FRAC_BITS +: LVL_W];
  assign hi    = info1.lo + info1.span;
  assign lo_b  = to_byte(info1.lo);
  assign mid_b = to_byte(mid);
  assign hi_b  = to_byte(hi);

  always_comb begin
    unique case (info1.sector)
      SEC_RED_YEL: {red_next, green_next, blue_next} = {hi_b, mid_b, lo_b};
      SEC_YEL_GRN: {red_next, green_next, blue_next} = {mid_b, hi_b, lo_b};
      SEC_GRN_CYN: {red_next, green_next, blue_next} = {lo_b, hi_b, mid_b};
      SEC_CYN_BLU: {red_next, green_next, blue_next} = {lo_b, mid_b, hi_b};
      SEC_BLU_MAG: {red_next, green_next, blue_next} = {mid_b, lo_b, hi_b};
      default:     {red_next, green_next, blue_next} = {hi_b, lo_b, mid_b};
    endcase
    // zero spread: plain grey, covers black and white too
    if (info1.special) begin
      red_next   = info1.grey;
      green_next = info1.grey;
      blue_next  = info1.grey;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign out_valid = v2;

`ifndef SYNTH
  // a zero-spread colour comes out grey
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (v1 && rdy2 && info1.special) |=> ((red == green) && (green == blue)))
    else $error("mix: zero-spread beat not grey");
`endif

endmodule

`default_nettype wire

### hw/rtl/hls_to_rgb_convert_top.sv
// hls_to_rgb_convert_top: hue / lightness / saturation to 8-bit rgb
// pipeline from input beat to result: 4 front stages,
// 6 root stages of up to three root bits each, 2 blend stages
// throughput one colour per cycle while out_ready is high; each stage moves when empty or drained
// reset (synchronous, active high) clears the valid bits only
// depends on hlsrgb_pkg, hlsrgb_front, hlsrgb_sqrt, hlsrgb_mix
`default_nettype none

module hls_to_rgb_convert_top
  import hlsrgb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [IN_W-1:0] hue_deg,
  input  wire logic [IN_W-1:0]        lightness,
  input  wire logic [IN_W-1:0]        saturation,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [BYTE_W-1:0]           red,
  output logic [BYTE_W-1:0]           green,
  output logic [BYTE_W-1:0]           blue
);

  logic                f_valid, f_ready, q_valid, q_ready;
  logic [LVL_W-1:0]    f_ratio;
  mix_t                f_info, q_info;
  logic [SQ_STEPS-1:0] q_root;

  // clamp, spread, hue wrap and ratio
  hlsrgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue_deg    (hue_deg),
    .lightness  (lightness),
    .saturation (saturation),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .ratio      (f_ratio),
    .info       (f_info)
  );

  // square-root hue curve
  hlsrgb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .ratio     (f_ratio),
    .in_info   (f_info),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .root      (q_root),
    .out_info  (q_info)
  );

  // middle level and channel bytes
  hlsrgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .root      (q_root),
    .in_info   (q_info),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire

### tb/hls_to_rgb_convert_checker.sv
// hls_to_rgb_convert_checker: watches both channels of the hls to rgb converter,
// predicts each colour on its input beat and compares result beats in order
// depends on hlsrgb_pkg
`timescale 1ns / 100ps

module hls_to_rgb_convert_checker
  import hlsrgb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic signed [IN_W-1:0] hue_deg,
  input  logic [IN_W-1:0]        lightness,
  input  logic [IN_W-1:0]        saturation,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [BYTE_W-1:0]      red,
  input  logic [BYTE_W-1:0]      green,
  input  logic [BYTE_W-1:0]      blue,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // expected colour plus the input that produced it, for reporting
  typedef struct {
    logic signed [IN_W-1:0] hue;
    logic [IN_W-1:0]        light;
    logic [IN_W-1:0]        sat;
    rgb_t                   rgb;
  } colour_exp_t;

  colour_exp_t colour_q[$];

  // floor(level * 255 / one)
  function automatic logic [BYTE_W-1:0] level_byte(input longint unsigned lvl);
    return BYTE_W'((lvl * 255) >> FRAC_BITS);
  endfunction

  // hue / lightness / saturation to rgb bytes
  function automatic rgb_t rgb_of_hls(input logic signed [IN_W-1:0] hue,
                                      input logic [IN_W-1:0] light,
                                      input logic [IN_W-1:0] sat);
    longint            h;
    longint            f;
    longint unsigned   l, s, d, lo, hi, mid, af, ratio, rad, q, trial;
    longint unsigned   one;
    longint unsigned   lvl[3];
    sector_t           sec;
    rgb_t              c;
    one = longint'(LVL_ONE);
    h   = hue;
    l   = light;
    s   = sat;
    if (l > one) l = one;
    if (s > one) s = one;
    // white and black short cuts
    if (l == one) return {8'd255, 8'd255, 8'd255};
    if (l == 0) return {8'd0, 8'd0, 8'd0};
    if (l <= longint'(LVL_HALF))
      d = (s * l) >> FRAC_BITS;
    else
      d = (s * (one - l)) >> FRAC_BITS;
    // zero spread gives a grey
    if (d == 0) begin
      c.red   = level_byte(l);
      c.green = c.red;
      c.blue  = c.red;
      return c;
    end
    lo = l - d;
    hi = l + d;
    // bring the hue into one turn
    while (h < 0) h = h + DEG360;
    while (h >= DEG360) h = h - DEG360;
    // distance to the nearest primary
    if (h < DEG60)
      f = h;
    else if (h < 3 * DEG60)
      f = h - 2 * DEG60;
    else if (h < 5 * DEG60)
      f = h - 4 * DEG60;
    else
      f = h - DEG360;
    af    = (f < 0) ? longint'(-f) : longint'(f);
    ratio = (af << FRAC_BITS) / longint'(DEG60);
    // floor of the square root, one bit at a time
    rad = ratio << FRAC_BITS;
    q   = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = q | (64'd1 << b);
      if (trial * trial <= rad) q = trial;
    end
    mid = lo + (((hi - lo) * q) >> FRAC_BITS);
    sec = sector_t'(h / DEG60);
    case (sec)
      SEC_RED_YEL: begin lvl[0] = hi;  lvl[1] = mid; lvl[2] = lo;  end
      SEC_YEL_GRN: begin lvl[0] = mid; lvl[1] = hi;  lvl[2] = lo;  end
      SEC_GRN_CYN: begin lvl[0] = lo;  lvl[1] = hi;  lvl[2] = mid; end
      SEC_CYN_BLU: begin lvl[0] = lo;  lvl[1] = mid; lvl[2] = hi;  end
      SEC_BLU_MAG: begin lvl[0] = mid; lvl[1] = lo;  lvl[2] = hi;  end
      default:     begin lvl[0] = hi;  lvl[1] = lo;  lvl[2] = mid; end
    endcase
    c.red   = level_byte(lvl[0]);
    c.green = level_byte(lvl[1]);
    c.blue  = level_byte(lvl[2]);
    return c;
  endfunction

  // result beats are popped before input beats are pushed in the same cycle
  always @(posedge clk) begin
    colour_exp_t want;
    colour_exp_t fresh;
    rgb_t        got;
    if (rst) begin
      colour_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {red, green, blue};
        if (colour_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with none expected: r=%0d g=%0d b=%0d",
                     $realtime, red, green, blue);
          fail_count <= fail_count + 1;
        end else begin
          want = colour_q.pop_front();
          if (want.rgb.red !== got.red || want.rgb.green !== got.green ||
              want.rgb.blue !== got.blue) begin
            if (fail_count < 10)
              $display("%0t: h=%0d l=%0d s=%0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.hue, want.light, want.sat,
                       want.rgb.red, want.rgb.green, want.rgb.blue,
                       got.red, got.green, got.blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.hue   = hue_deg;
        fresh.light = lightness;
        fresh.sat   = saturation;
        fresh.rgb   = rgb_of_hls(hue_deg, lightness, saturation);
        colour_q.push_back(fresh);
      end
      pending <= colour_q.size();
    end
  end

endmodule

### tb/hls_to_rgb_convert_top_tb.sv
// hls_to_rgb_convert_top_tb: drives hue / lightness / saturation beats with random
// gaps and stalls into the converter and gives the verdict
// depends on hlsrgb_pkg, hls_to_rgb_convert_top, hls_to_rgb_convert_checker
`timescale 1ns / 100ps

module hls_to_rgb_convert_top_tb;
  import hlsrgb_pkg::*;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic signed [IN_W-1:0] hue_deg    = '0;
  logic [IN_W-1:0]        lightness  = '0;
  logic [IN_W-1:0]        saturation = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [BYTE_W-1:0]      red;
  logic [BYTE_W-1:0]      green;
  logic [BYTE_W-1:0]      blue;

  int fail_count;
  int pending;
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;
  int rx_wait  = 0;
  int rx_draw;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hls_to_rgb_convert_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue_deg    (hue_deg),
    .lightness  (lightness),
    .saturation (saturation),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hls_to_rgb_convert_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue_deg    (hue_deg),
    .lightness  (lightness),
    .saturation (saturation),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: after each result beat, drop out_ready for a random stall, or none when quiet_rx is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      rx_draw = quiet_rx ? 0 : $urandom_range(0, 4);
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one input beat, after a random idle gap, or none when quiet_tx is set
  task automatic send_colour(input logic signed [IN_W-1:0] h,
                             input logic [IN_W-1:0] l,
                             input logic [IN_W-1:0] s);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue_deg    <= h;
    lightness  <= l;
    saturation <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender off until every expected colour has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic signed [IN_W-1:0] h;
    logic [IN_W-1:0]        l;
    logic [IN_W-1:0]        s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sector edges, range ends, white, black, clamps and greys
    send_colour(-17'sd23040, 17'd32768, 17'd65536);
    send_colour(17'sd46079, 17'd32768, 17'd65536);
    send_colour(17'sd0, 17'd32768, 17'd65536);
    send_colour(-17'sd1, 17'd32768, 17'd65536);
    send_colour(17'sd3840, 17'd32768, 17'd65536);
    send_colour(17'sd7680, 17'd40000, 17'd65536);
    send_colour(17'sd11520, 17'd20000, 17'd65536);
    send_colour(17'sd15360, 17'd32769, 17'd50000);
    send_colour(17'sd19200, 17'd32767, 17'd65536);
    send_colour(17'sd23039, 17'd32768, 17'd65536);
    send_colour(17'sd23040, 17'd32768, 17'd65536);
    send_colour(17'sd1920, 17'd32768, 17'd65536);
    send_colour(-17'sd65536, 17'd30000, 17'd65536);
    send_colour(17'sd65535, 17'd30000, 17'd65536);
    send_colour(17'sd5000, 17'd65536, 17'd65536);
    send_colour(17'sd5000, 17'd70000, 17'd12345);
    send_colour(17'sd5000, 17'd131071, 17'd131071);
    send_colour(17'sd5000, 17'd0, 17'd65536);
    send_colour(17'sd5000, 17'd40000, 17'd0);
    send_colour(17'sd5000, 17'd1, 17'd1);
    send_colour(17'sd5000, 17'd65535, 17'd65536);
    send_colour(17'sd9000, 17'd1, 17'd65536);
    send_colour(17'sd9000, 17'd30000, 17'd131071);
    drain_results();

    // random colours, mostly well inside range with edges mixed in
    for (int i = 0; i < 700; i++) begin
      if (i % 60 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      if (i == 350) drain_results();
      case ($urandom_range(0, 9))
        0:       h = IN_W'($urandom);
        1:       h = IN_W'($urandom_range(0, 6) * DEG60 + $urandom_range(0, 4) - 2);
        default: h = IN_W'(int'($urandom_range(0, 69119)) - 23040);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 6))
            0:       l = 17'd0;
            1:       l = 17'd65536;
            2:       l = 17'd32768;
            3:       l = 17'd32767;
            4:       l = 17'd32769;
            5:       l = 17'd1;
            default: l = 17'd65535;
          endcase
        end
        1:       l = IN_W'($urandom_range(65537, 131071));
        default: l = IN_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 9))
        0:       s = ($urandom_range(0, 1) == 0) ? 17'd0 : 17'd65536;
        1:       s = IN_W'($urandom_range(65537, 131071));
        2:       s = IN_W'($urandom_range(0, 16));
        default: s = IN_W'($urandom_range(0, 65536));
      endcase
      send_colour(h, l, s);
    end

    // let the pipeline empty, then keep watching for stray beats
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("hls_to_rgb_convert_top regression: pass");
    else
      $display("hls_to_rgb_convert_top regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("hls_to_rgb_convert_top regression: fail");
    $finish;
  end

endmodule

### hls_to_rgb_convert_top.f
hw/rtl/hlsrgb_pkg.sv
hw/rtl/hlsrgb_front.sv
hw/rtl/hlsrgb_sqrt.sv
hw/rtl/hlsrgb_mix.sv
hw/rtl/hls_to_rgb_convert_top.sv
tb/hls_to_rgb_convert_checker.sv
tb/hls_to_rgb_convert_top_tb.sv
